// File: sv/rational_normalize_divide_defines.svh
// Assertion macros for the rational normalize and divide block.
`ifndef RATIONAL_NORMALIZE_DIVIDE_DEFINES_SVH
`define RATIONAL_NORMALIZE_DIVIDE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define RND_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Clocked check that also holds while reset is asserted.
`define RND_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define RND_ASSERT(lbl, prop, msg)
`define RND_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: sv/rnd_pkg.sv
// Shared types, constants and microcode store of the rational normalize and divide block.
`timescale 1ns / 1ps

package rnd_pkg;

  // Result word size used for the overflow limits
  localparam int unsigned WORD_BITS = 32;
  // Field, product and counter widths
  localparam int unsigned FW    = 32;
  localparam int unsigned PW    = 2 * FW;
  localparam int unsigned DEN_W = 31;
  localparam int unsigned KW    = 6;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned UPC_W = 4;

  // Largest positive magnitude plus one, 2^(WORD_BITS-1)
  localparam logic [PW-1:0] HALF = PW'(1) << (WORD_BITS - 1);

  // Request kinds carried in tuser
  localparam logic REQ_REDUCE = 1'b0;
  localparam logic REQ_DIVIDE = 1'b1;

  typedef logic [UPC_W-1:0] rnd_upc_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } rnd_status_e;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_CHECK, OP_MULN, OP_MULD, OP_INITG, OP_STRIP2, OP_STRIPU,
    OP_GCD, OP_MKG, OP_DIVN, OP_SETD, OP_DIVD, OP_FIN, OP_ZERO, OP_EMIT
  } rnd_op_e;

  // Jump conditions
  typedef enum logic [3:0] {
    C_ALWAYS, C_NO_IN, C_ERR, C_N_ZERO, C_BOTH_EVEN, C_U_EVEN, C_V_NZ, C_CNT_NZ,
    C_OUT_BUSY
  } rnd_cond_e;

  typedef struct packed {
    rnd_op_e   op;
    rnd_cond_e cond;
    rnd_upc_t  jmp;
  } rnd_ctrl_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic err;
    logic n_zero;
    logic both_even;
    logic u_even;
    logic v_nz;
    logic cnt_nz;
  } rnd_flags_t;

  typedef struct packed {
    logic          req_type;
    logic [FW-1:0] a_num;
    logic [FW-1:0] a_den;
    logic [FW-1:0] b_num;
    logic [FW-1:0] b_den;
  } rnd_req_t;

  typedef struct packed {
    logic [FW-1:0]    res_num;
    logic [DEN_W-1:0] res_den;
    rnd_status_e      status;
  } rnd_res_t;

  // Program step addresses
  localparam rnd_upc_t STEP_ACCEPT = rnd_upc_t'(0);
  localparam rnd_upc_t STEP_CHECK  = rnd_upc_t'(1);
  localparam rnd_upc_t STEP_MULN   = rnd_upc_t'(2);
  localparam rnd_upc_t STEP_MULD   = rnd_upc_t'(3);
  localparam rnd_upc_t STEP_INITG  = rnd_upc_t'(4);
  localparam rnd_upc_t STEP_STRIP2 = rnd_upc_t'(5);
  localparam rnd_upc_t STEP_STRIPU = rnd_upc_t'(6);
  localparam rnd_upc_t STEP_GCD    = rnd_upc_t'(7);
  localparam rnd_upc_t STEP_MKG    = rnd_upc_t'(8);
  localparam rnd_upc_t STEP_DIVN   = rnd_upc_t'(9);
  localparam rnd_upc_t STEP_SETD   = rnd_upc_t'(10);
  localparam rnd_upc_t STEP_DIVD   = rnd_upc_t'(11);
  localparam rnd_upc_t STEP_FIN    = rnd_upc_t'(12);
  localparam rnd_upc_t STEP_ZERO   = rnd_upc_t'(13);
  localparam rnd_upc_t STEP_SPARE  = rnd_upc_t'(14);
  localparam rnd_upc_t STEP_EMIT   = rnd_upc_t'(15);

  // Control store: next step is jmp when cond holds, else the following step
  function automatic rnd_ctrl_t rnd_ucode(rnd_upc_t upc);
    rnd_ctrl_t w;
    case (upc)
      STEP_ACCEPT: w = '{op: OP_LOAD,   cond: C_NO_IN,     jmp: STEP_ACCEPT};
      STEP_CHECK:  w = '{op: OP_CHECK,  cond: C_ERR,       jmp: STEP_EMIT};
      STEP_MULN:   w = '{op: OP_MULN,   cond: C_ALWAYS,    jmp: STEP_MULD};
      STEP_MULD:   w = '{op: OP_MULD,   cond: C_ALWAYS,    jmp: STEP_INITG};
      STEP_INITG:  w = '{op: OP_INITG,  cond: C_N_ZERO,    jmp: STEP_ZERO};
      STEP_STRIP2: w = '{op: OP_STRIP2, cond: C_BOTH_EVEN, jmp: STEP_STRIP2};
      STEP_STRIPU: w = '{op: OP_STRIPU, cond: C_U_EVEN,    jmp: STEP_STRIPU};
      STEP_GCD:    w = '{op: OP_GCD,    cond: C_V_NZ,      jmp: STEP_GCD};
      STEP_MKG:    w = '{op: OP_MKG,    cond: C_ALWAYS,    jmp: STEP_DIVN};
      STEP_DIVN:   w = '{op: OP_DIVN,   cond: C_CNT_NZ,    jmp: STEP_DIVN};
      STEP_SETD:   w = '{op: OP_SETD,   cond: C_ALWAYS,    jmp: STEP_DIVD};
      STEP_DIVD:   w = '{op: OP_DIVD,   cond: C_CNT_NZ,    jmp: STEP_DIVD};
      STEP_FIN:    w = '{op: OP_FIN,    cond: C_ALWAYS,    jmp: STEP_EMIT};
      STEP_ZERO:   w = '{op: OP_ZERO,   cond: C_ALWAYS,    jmp: STEP_EMIT};
      STEP_SPARE:  w = '{op: OP_NOP,    cond: C_ALWAYS,    jmp: STEP_ACCEPT};
      STEP_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY,  jmp: STEP_EMIT};
      default:     w = '{op: OP_NOP,    cond: C_ALWAYS,    jmp: STEP_ACCEPT};
    endcase
    return w;
  endfunction

  // Magnitude of a two's complement field; the most negative value maps to 2^(FW-1)
  function automatic logic [FW-1:0] rnd_mag(logic [FW-1:0] v);
    return v[FW-1] ? (~v + FW'(1)) : v;
  endfunction

endpackage

// File: sv/rnd_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps
`include "rational_normalize_divide_defines.svh"

module rnd_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rnd_pkg::rnd_flags_t flags_i,
  input  logic               in_valid_i,
  input  logic               out_free_i,
  output rnd_pkg::rnd_ctrl_t  ctrl_o
);
  import rnd_pkg::*;

  rnd_upc_t  upc_q, upc_d;
  rnd_ctrl_t ctrl;
  logic      hit;

  assign ctrl   = rnd_ucode(upc_q);
  assign ctrl_o = ctrl;

  // Jump condition select
  always_comb begin
    case (ctrl.cond)
      C_ALWAYS:    hit = 1'b1;
      C_NO_IN:     hit = !in_valid_i;
      C_ERR:       hit = flags_i.err;
      C_N_ZERO:    hit = flags_i.n_zero;
      C_BOTH_EVEN: hit = flags_i.both_even;
      C_U_EVEN:    hit = flags_i.u_even;
      C_V_NZ:      hit = flags_i.v_nz;
      C_CNT_NZ:    hit = flags_i.cnt_nz;
      C_OUT_BUSY:  hit = !out_free_i;
      default:     hit = 1'b1;
    endcase
  end

  // Next step; the last step wraps to the accept step
  assign upc_d = hit ? ctrl.jmp : (upc_q + rnd_upc_t'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_ACCEPT;
    end else begin
      upc_q <= upc_d;
    end
  end

  `RND_ASSERT_ALWAYS(a_reset_step, !rst_ni |-> (upc_q == STEP_ACCEPT), "step not cleared by reset")
  `RND_ASSERT(a_wait_hold, (upc_q == STEP_ACCEPT && !in_valid_i) |=> (upc_q == STEP_ACCEPT), "left accept without a request")
  `RND_ASSERT(a_emit_hold, (upc_q == STEP_EMIT && !out_free_i) |=> (upc_q == STEP_EMIT), "left emit while output busy")
  `RND_ASSERT(a_emit_done, (upc_q == STEP_EMIT && out_free_i) |=> (upc_q == STEP_ACCEPT), "emit did not return to accept")

endmodule

// File: sv/rnd_datapath.sv
// Datapath: operand latch, shared multiplier, binary gcd unit and serial divider.
`timescale 1ns / 1ps
`include "rational_normalize_divide_defines.svh"

module rnd_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rnd_pkg::rnd_ctrl_t  ctrl_i,
  input  rnd_pkg::rnd_req_t   req_i,
  output rnd_pkg::rnd_flags_t flags_o,
  output rnd_pkg::rnd_res_t   res_o
);
  import rnd_pkg::*;

  rnd_req_t         req_q;
  rnd_res_t         res_q;
  logic             neg_q;
  logic [PW-1:0]    n_q, d_q, u_q, v_q, r_q, q_q;
  logic [KW-1:0]    k_q;
  logic [CNT_W-1:0] cnt_q;

  rnd_status_e      err_st;
  logic [FW-1:0]    mul_a, mul_b;
  logic [PW-1:0]    prod;
  logic [PW-1:0]    rs, rs_sub;
  logic             rs_ge;
  logic [PW-1:0]    num_mag;
  logic             ovf;

  // Error screening: zero denominators first, then a zero divisor
  always_comb begin
    if (req_q.a_den == '0) begin
      err_st = ST_ZERO_DEN;
    end else if (req_q.req_type && req_q.b_den == '0) begin
      err_st = ST_ZERO_DEN;
    end else if (req_q.req_type && req_q.b_num == '0) begin
      err_st = ST_DIV_ZERO;
    end else begin
      err_st = ST_OK;
    end
  end

  // Shared 32x32 multiplier; a reduce request multiplies by one
  assign mul_a = rnd_mag((ctrl_i.op == OP_MULN) ? req_q.a_num : req_q.a_den);
  assign mul_b = !req_q.req_type ? FW'(1)
               : rnd_mag((ctrl_i.op == OP_MULN) ? req_q.b_den : req_q.b_num);
  assign prod  = PW'(mul_a) * PW'(mul_b);

  // Restoring divide step, divisor is the gcd in u_q
  assign rs     = {r_q[PW-2:0], q_q[PW-1]};
  assign rs_ge  = (rs >= u_q);
  assign rs_sub = rs - u_q;

  // Final range check; q_q holds the reduced denominator magnitude
  assign num_mag = neg_q ? (~n_q + PW'(1)) : n_q;
  assign ovf     = (q_q > (HALF - PW'(1))) ||
                   (neg_q ? (n_q > HALF) : (n_q > (HALF - PW'(1))));

  // Main datapath registers, one operation per step
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LOAD: begin
        req_q <= req_i;
      end
      OP_CHECK: begin
        neg_q <= req_q.a_num[FW-1] ^ req_q.a_den[FW-1] ^
                 (req_q.req_type & (req_q.b_num[FW-1] ^ req_q.b_den[FW-1]));
        res_q <= '{res_num: '0, res_den: '0, status: err_st};
      end
      OP_MULN: n_q <= prod;
      OP_MULD: d_q <= prod;
      OP_INITG: begin
        u_q <= n_q;
        v_q <= d_q;
        k_q <= '0;
      end
      OP_STRIP2: begin
        if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + KW'(1);
        end
      end
      OP_STRIPU: begin
        if (!u_q[0]) u_q <= u_q >> 1;
      end
      OP_GCD: begin
        // u stays odd; v is halved when even, else replaced by |u - v|
        if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q > v_q) begin
          u_q <= v_q;
          v_q <= u_q - v_q;
        end else begin
          v_q <= v_q - u_q;
        end
      end
      OP_MKG: begin
        u_q <= u_q << k_q;
        r_q <= '0;
        q_q <= n_q;
      end
      OP_DIVN, OP_DIVD: begin
        r_q <= rs_ge ? rs_sub : rs;
        q_q <= {q_q[PW-2:0], rs_ge};
      end
      OP_SETD: begin
        n_q <= q_q;
        r_q <= '0;
        q_q <= d_q;
      end
      OP_FIN: begin
        if (ovf) begin
          res_q <= '{res_num: '0, res_den: '0, status: ST_OVERFLOW};
        end else begin
          res_q <= '{res_num: num_mag[FW-1:0], res_den: q_q[DEN_W-1:0], status: ST_OK};
        end
      end
      OP_ZERO: begin
        res_q <= '{res_num: '0, res_den: DEN_W'(1), status: ST_OK};
      end
      default: ;
    endcase
  end

  // Divide loop counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (ctrl_i.op)
        OP_MKG, OP_SETD:  cnt_q <= '1;
        OP_DIVN, OP_DIVD: cnt_q <= cnt_q - CNT_W'(1);
        default: ;
      endcase
    end
  end

  assign flags_o = '{
    err:       (err_st != ST_OK),
    n_zero:    (n_q == '0),
    both_even: (!u_q[0] && !v_q[0]),
    u_even:    !u_q[0],
    v_nz:      (v_q != '0),
    cnt_nz:    (cnt_q != '0)
  };
  assign res_o = res_q;

  `RND_ASSERT(a_gcd_nonzero, (ctrl_i.op == OP_MKG) |=> (u_q != '0), "gcd came out zero")
  `RND_ASSERT(a_rem_below_g, (ctrl_i.op == OP_DIVN || ctrl_i.op == OP_DIVD) |=> (r_q < u_q), "remainder not below gcd")
  `RND_ASSERT(a_err_status, (ctrl_i.op == OP_CHECK && flags_o.err) |=> (res_q.status != ST_OK), "error request staged as ok")

endmodule

// File: sv/rational_normalize_divide.sv
// Top level of the rational normalize and divide block: sequencer, datapath, output register.
//
//  channel  dir  ports               payload
//  s_axis   in   tvalid/tready       tdata: a_num, a_den, b_num, b_den; tuser: req_type
//  m_axis   out  tvalid/tready       tdata: res_num, res_den, pad; tuser: status
//
//  One request at a time. Error requests and zero numerators skip the gcd and the
//  divisions. Other requests run the binary gcd loop (one step per common factor of
//  two, per stripped factor of u, per gcd step), then the two serial divisions of the
//  64-bit products by the gcd, which dominate. Reset clears the step counter and the
//  output valid. A new request is taken as soon as the previous result is in the output
//  register; a stalled output holds the sequencer in its emit step.
`timescale 1ns / 1ps

module rational_normalize_divide (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  logic         s_axis_tuser,   // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // res_num[31:0], res_den[62:32], zero[63]
  output logic [1:0]   m_axis_tuser    // status
);
  import rnd_pkg::*;

  rnd_ctrl_t  ctrl;
  rnd_flags_t flags;
  rnd_req_t   req;
  rnd_res_t   res;
  rnd_res_t   out_q;
  logic       out_valid_q;
  logic       out_free;
  logic       emit;

  assign req = '{
    req_type: s_axis_tuser,
    a_num:    s_axis_tdata[31:0],
    a_den:    s_axis_tdata[63:32],
    b_num:    s_axis_tdata[95:64],
    b_den:    s_axis_tdata[127:96]
  };

  assign s_axis_tready = (ctrl.op == OP_LOAD);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign emit          = (ctrl.op == OP_EMIT) && out_free;

  rnd_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flags_i    (flags),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  rnd_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .req_i   (req),
    .flags_o (flags),
    .res_o   (res)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (emit) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.res_den, out_q.res_num};
  assign m_axis_tuser  = out_q.status;

endmodule

// File: tb/rnd_fraction_checker.sv
// Checker for the rational normalize and divide block: predicts each result and compares.
`timescale 1ns / 1ps

module rnd_fraction_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [127:0] s_tdata_i,    // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  logic         s_tuser_i,    // req_type
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [63:0]  m_tdata_i,    // res_num[31:0], res_den[62:32], zero[63]
  input  logic [1:0]   m_tuser_i,    // status
  output int unsigned  mismatch_count_o,
  output int unsigned  pending_o
);
  import rnd_pkg::*;

  rnd_res_t expected_fractions[$];

  // Magnitude of a signed 32-bit field, widened so the most negative value fits
  function automatic logic [63:0] magnitude_of(logic [FW-1:0] v);
    logic [63:0] w;
    w = {32'd0, v};
    return v[FW-1] ? (64'h1_0000_0000 - w) : w;
  endfunction

  // Expected result of one request: reduced fraction or quotient, or an error code
  function automatic rnd_res_t reduced_quotient(logic req, logic [FW-1:0] an, logic [FW-1:0] ad,
                                                logic [FW-1:0] bn, logic [FW-1:0] bd);
    rnd_res_t    r;
    logic        neg;
    logic [63:0] mn, md, x, y, t, half;
    r = '{res_num: '0, res_den: '0, status: ST_OK};
    if (ad == '0) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    if (req == REQ_DIVIDE) begin
      // zero denominator wins over division by zero
      if (bd == '0) begin
        r.status = ST_ZERO_DEN;
        return r;
      end
      if (bn == '0) begin
        r.status = ST_DIV_ZERO;
        return r;
      end
      neg = (an[FW-1] ^ bd[FW-1]) ^ (bn[FW-1] ^ ad[FW-1]);
      mn  = magnitude_of(an) * magnitude_of(bd);
      md  = magnitude_of(bn) * magnitude_of(ad);
    end else begin
      neg = an[FW-1] ^ ad[FW-1];
      mn  = magnitude_of(an);
      md  = magnitude_of(ad);
    end
    // Euclid on the 64-bit magnitudes; md is never zero here
    x = mn;
    y = md;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    mn = mn / x;
    md = md / x;
    if (mn == 0) begin
      md  = 64'd1;
      neg = 1'b0;
    end
    half = 64'd1 << (WORD_BITS - 1);
    if (md > half - 1 || (neg ? (mn > half) : (mn > half - 1))) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    r.res_num = neg ? FW'(~mn + 64'd1) : FW'(mn);
    r.res_den = DEN_W'(md);
    return r;
  endfunction

  // Compare each delivered result with the oldest prediction, then record new requests
  always @(posedge clk_i) begin
    rnd_res_t    exp_r;
    logic [FW-1:0]    act_num;
    logic [DEN_W-1:0] act_den;
    logic        act_pad;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        act_num = m_tdata_i[31:0];
        act_den = m_tdata_i[62:32];
        act_pad = m_tdata_i[63];
        if (expected_fractions.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("[%0t] unexpected result num=%0d den=%0d status=%0d", $realtime,
                     $signed(act_num), act_den, m_tuser_i);
          mismatch_count_o++;
        end else begin
          exp_r = expected_fractions.pop_front();
          if (act_num !== exp_r.res_num || act_den !== exp_r.res_den ||
              m_tuser_i !== exp_r.status || act_pad !== 1'b0) begin
            if (mismatch_count_o < 10)
              $display(
                "[%0t] mismatch: exp num=%0d den=%0d st=%s, got num=%0d den=%0d st=%0d pad=%b",
                $realtime, $signed(exp_r.res_num), exp_r.res_den, exp_r.status.name(),
                $signed(act_num), act_den, m_tuser_i, act_pad);
            mismatch_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        expected_fractions.push_back(reduced_quotient(s_tuser_i, s_tdata_i[31:0],
                                                      s_tdata_i[63:32], s_tdata_i[95:64],
                                                      s_tdata_i[127:96]));
      pending_o = expected_fractions.size();
    end
  end

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

endmodule

// File: tb/testbench.sv
// Top of the rational normalize and divide testbench: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module testbench;
  import rnd_pkg::*;

  localparam logic [31:0] MOST_NEG    = 32'h8000_0000;
  localparam logic [31:0] MOST_POS    = 32'h7fff_ffff;
  localparam logic [31:0] MINUS_ONE   = 32'hffff_ffff;
  localparam int unsigned RANDOM_REQS = 800;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  logic         s_axis_tuser;   // req_type
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;   // res_num[31:0], res_den[62:32], zero[63]
  logic [1:0]   m_axis_tuser;   // status

  int unsigned  mismatch_count;
  int unsigned  pending;
  int unsigned  cycle_count;
  logic         gaps_on;
  logic         hold_off_req;

  rational_normalize_divide i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  rnd_fraction_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tuser_i        (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Field value: full random, small, extremes, shifted bytes or shifted words
  function automatic logic [31:0] pick_value();
    int unsigned sel;
    logic [31:0] v;
    sel = $urandom_range(99);
    if (sel < 35) return $urandom;
    if (sel < 60) return 32'($urandom_range(0, 200)) - 32'd100;
    if (sel < 70) begin
      case ($urandom_range(4))
        0:       return MOST_NEG;
        1:       return MOST_POS;
        2:       return MINUS_ONE;
        3:       return 32'd1;
        default: return 32'd0;
      endcase
    end
    if (sel < 85) v = 32'($urandom_range(1, 255)) << $urandom_range(0, 23);
    else          v = $urandom >> $urandom_range(0, 31);
    return $urandom_range(1) ? (~v + 32'd1) : v;
  endfunction

  // Offer one request and hold it until accepted; called at a falling edge
  task automatic offer_request(input logic req, input logic [31:0] an, input logic [31:0] ad,
                               input logic [31:0] bn, input logic [31:0] bd);
    if (gaps_on) begin
      while ($urandom_range(99) < 17) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk_i);
      end
      // an occasional long gap shifts the next request against the block's steps
      if ($urandom_range(99) < 4) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 400)) @(negedge clk_i);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = req;
    s_axis_tdata  = {bd, bn, ad, an};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready = !(gaps_on && $urandom_range(99) < 17);
    end
  end

  // Stimulus and verdict
  initial begin
    logic        req;
    logic [31:0] an, ad, bn, bd;
    logic [31:0] k;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_REDUCE;
    gaps_on       = 1'b1;
    hold_off_req  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: signs, zero cases, extremes, error precedence
    offer_request(REQ_REDUCE, 32'd6, 32'd4, $urandom, $urandom);
    offer_request(REQ_REDUCE, -32'd6, 32'd4, 32'd0, 32'd0);
    offer_request(REQ_REDUCE, 32'd6, -32'd4, 32'd0, 32'd0);
    offer_request(REQ_REDUCE, -32'd6, -32'd4, MOST_NEG, MINUS_ONE);
    offer_request(REQ_REDUCE, 32'd0, -32'd5, 32'd0, 32'd0);
    offer_request(REQ_REDUCE, 32'd5, 32'd0, 32'd3, 32'd3);
    offer_request(REQ_REDUCE, MOST_NEG, MINUS_ONE, 32'd0, 32'd0);
    offer_request(REQ_REDUCE, MOST_NEG, 32'd1, 32'd0, 32'd0);
    offer_request(REQ_REDUCE, MOST_NEG, MOST_NEG, 32'd0, 32'd0);
    offer_request(REQ_REDUCE, 32'd7, MOST_NEG, 32'd0, 32'd0);
    offer_request(REQ_REDUCE, MOST_POS, MINUS_ONE, 32'd0, 32'd0);
    offer_request(REQ_REDUCE, MINUS_ONE, MOST_POS, 32'd0, 32'd0);
    offer_request(REQ_REDUCE, 32'h4000_0000, 32'hc000_0000, MOST_POS, MOST_POS);
    offer_request(REQ_DIVIDE, 32'd3, 32'd0, 32'd0, 32'd5);
    offer_request(REQ_DIVIDE, 32'd3, 32'd4, 32'd0, 32'd0);
    offer_request(REQ_DIVIDE, 32'd3, 32'd4, 32'd0, 32'd5);
    offer_request(REQ_DIVIDE, 32'd1, 32'd2, 32'd3, 32'd4);
    offer_request(REQ_DIVIDE, 32'd0, -32'd3, -32'd5, 32'd7);
    offer_request(REQ_DIVIDE, MOST_POS, 32'd1, 32'd1, MOST_POS);
    offer_request(REQ_DIVIDE, MOST_NEG, 32'd1, MINUS_ONE, 32'd1);
    offer_request(REQ_DIVIDE, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
    offer_request(REQ_DIVIDE, MOST_NEG, 32'd1, 32'd1, 32'd1);
    offer_request(REQ_DIVIDE, -32'd3, -32'd4, -32'd9, -32'd8);
    offer_request(REQ_DIVIDE, 32'd1, MOST_POS, MOST_POS, 32'd1);
    offer_request(REQ_DIVIDE, 32'h4000_0000, 32'd3, 32'h4000_0000, -32'd3);

    // random requests, often with shared factors so the gcd loop runs long
    for (int unsigned i = 0; i < RANDOM_REQS; i++) begin
      gaps_on = !(i >= 300 && i < 450);
      if (i == 100) hold_off_req = 1'b1;
      req = ($urandom_range(99) < 60) ? REQ_DIVIDE : REQ_REDUCE;
      an  = pick_value();
      ad  = pick_value();
      bn  = pick_value();
      bd  = pick_value();
      if ($urandom_range(99) < 40) begin
        k  = 32'($urandom_range(2, 5000));
        an = an * k;
        ad = ad * k;
      end
      if ($urandom_range(99) < 30) begin
        k  = 32'($urandom_range(2, 5000));
        bn = bn * k;
        bd = bd * k;
      end
      offer_request(req, an, ad, bn, bd);
    end
    s_axis_tvalid = 1'b0;
    gaps_on       = 1'b1;

    // drain, then allow for the block's longest request
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
